### src/gyro_bias_calibrate_convert_defines.svh
// ----------------------------------------------------------------------------
// Gyro bias calibration assertion macros
// Shared concurrent assertion forms for the gyro bias calibration block.
// ----------------------------------------------------------------------------
`ifndef GYRO_BIAS_CALIBRATE_CONVERT_DEFINES_SVH
`define GYRO_BIAS_CALIBRATE_CONVERT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### src/gbcc_pkg.sv
// ----------------------------------------------------------------------------
// Gyro bias calibration package
// Widths, constants, status codes, sequencer states and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package gbcc_pkg;

	// Field widths
	localparam int RAW_W      = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int RATE_W     = 25;
	localparam int TEMP_W     = 17;
	localparam int STATUS_W   = 3;
	localparam int NUM_AXES   = 3;
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 96;

	// Parameter defaults
	localparam int FRAC_BITS_DEF  = 8;
	localparam int COUNT_BITS_DEF = 16;

	// Register reset values
	localparam logic [CFG_W-1:0] CAL_SAMPLES_RST = 16'd100;
	localparam logic [CFG_W-1:0] DPS_RST         = 16'd4559;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_CAL_SAMPLES = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DPS_PER_LSB = 2'd1;

	// Saturation limits
	localparam int RATE_MAX = (1 << (RATE_W - 1)) - 1;
	localparam int RATE_MIN = -(1 << (RATE_W - 1));
	localparam int RATE_NEG_MAG = 1 << (RATE_W - 1);
	localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
	localparam int TEMP_MIN = -(1 << (TEMP_W - 1));

	// Temperature conversion constants
	localparam int TEMP_OFFSET_RAW = 13200;
	localparam int TEMP_DIV        = 280;
	localparam int TEMP_DIV_W      = 9;
	localparam int TEMP_BASE_C     = 35;
	localparam int DPS_SHIFT       = 16;

	localparam logic [1:0] AX_LAST = 2'd2;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_READING    = 3'd0,
		STS_READ_FAIL  = 3'd1,
		STS_CAL_SAMPLE = 3'd2,
		STS_CAL_OK     = 3'd3,
		STS_CAL_FAIL   = 3'd4,
		STS_CAL_START  = 3'd5
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_SAT,
		ST_TLOAD,
		ST_TDIV,
		ST_TFIX,
		ST_BLOAD,
		ST_BDIV,
		ST_BFIX,
		ST_DONE
	} seq_state_t;

	// Sequencer strobes to the datapath
	typedef struct packed {
		logic take;
		logic temp_load;
		logic bias_load;
		logic div_step;
		logic emit;
	} seq_ctrl_t;

endpackage

`default_nettype wire

### src/gyro_bias_calibrate_convert.sv
// ----------------------------------------------------------------------------
// Gyro bias calibration and rate conversion
// Averages raw gyro samples into a per-axis bias during a calibration run and
// converts later samples into bias-corrected rates and a temperature, Q8.
// ----------------------------------------------------------------------------
// The block takes one item at a time and gives one result per item. A start
// request, a calibration sample that does not end the run, and a failed read
// go straight to the result. A reading sends its three rate products through
// one multiplier in three steps each, then the temperature goes through the
// shared one-bit-per-cycle divider, DIV_W = 16 + COUNT_BITS + 1 + FRAC_BITS
// bits wide. The sample that ends a run with good samples makes one divider
// pass per axis bias. Input is taken again once the result is moved to the
// output register, which holds it until its transfer.
`default_nettype none

`include "gyro_bias_calibrate_convert_defines.svh"

module gyro_bias_calibrate_convert
	import gbcc_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// Input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// gyro_x[15:0], gyro_y[31:16], gyro_z[47:32], temp_raw[63:48]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// req_type[0], sample_ok[1]
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	// Result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// rate_x[24:0], rate_y[49:25], rate_z[74:50], temp_q8[91:75], zeros above
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// status[2:0]
	output logic [STATUS_W-1:0]        m_tuser
);

	localparam int SUM_W     = RAW_W + COUNT_BITS + 1;
	localparam int DIV_W     = SUM_W + FRAC_BITS;
	localparam int DVS_W     = (COUNT_BITS > TEMP_DIV_W) ? COUNT_BITS : TEMP_DIV_W;
	localparam int CNT_W     = $clog2(DIV_W + 1);
	localparam int DIFF_W    = ((RAW_W + FRAC_BITS > RATE_W) ? RAW_W + FRAC_BITS : RATE_W) + 1;
	localparam int PROD_W    = DIFF_W + CFG_W + 1;
	localparam int TQ_W      = RAW_W + FRAC_BITS;
	localparam int TSUM_W    = TQ_W + 2;
	localparam int TN_W      = RAW_W + 1;
	localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

	// Configuration registers
	logic [CFG_W-1:0] cal_samples_q;
	logic [CFG_W-1:0] dps_q;

	// Architectural state
	logic                    cal_q;
	logic [COUNT_BITS-1:0]   left_q;
	logic [COUNT_BITS-1:0]   good_q;
	logic signed [SUM_W-1:0] sum_q [NUM_AXES];
	logic signed [RATE_W-1:0] bias_q [NUM_AXES];

	// Sequencer
	seq_state_t state_q, state_d;
	seq_ctrl_t  ctrl;
	logic [1:0] ax_q;

	// Working registers
	logic signed [RAW_W-1:0]  raw_q [NUM_AXES];
	logic signed [RAW_W-1:0]  traw_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [RATE_W-1:0] rate_q [NUM_AXES];
	logic signed [TEMP_W-1:0] temp_q;
	status_t                  status_q;

	// Shared divider
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;

	// Output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]   m_tuser_q;

	// Input unpacking and decisions taken at the input transfer
	logic                    in_req;
	logic                    in_ok;
	logic signed [RAW_W-1:0] in_gyro [NUM_AXES];
	logic signed [RAW_W-1:0] in_temp;
	logic [COUNT_BITS-1:0]   start_cnt;
	logic [COUNT_BITS-1:0]   good_nxt;
	logic                    run_ends;

	always_comb begin
		in_req     = s_tuser[0];
		in_ok      = s_tuser[1];
		in_gyro[0] = s_tdata[15:0];
		in_gyro[1] = s_tdata[31:16];
		in_gyro[2] = s_tdata[47:32];
		in_temp    = s_tdata[63:48];
		start_cnt  = (cal_samples_q > CFG_W'(COUNT_MAX)) ? COUNT_BITS'(COUNT_MAX)
		                                                 : cal_samples_q[COUNT_BITS-1:0];
		good_nxt   = good_q + COUNT_BITS'(in_ok);
		run_ends   = (left_q == COUNT_BITS'(1));
	end

	// Divider step: one quotient bit per cycle
	logic [DVS_W:0] div_rem_w;
	logic           div_ge;
	logic [DVS_W:0] div_rem_nxt;

	always_comb begin
		div_rem_w   = {rem_q, quo_q[DIV_W-1]};
		div_ge      = (div_rem_w >= {1'b0, dvs_q});
		div_rem_nxt = div_ge ? (div_rem_w - {1'b0, dvs_q}) : div_rem_w;
	end

	// Operand selection for divider loads
	logic signed [TN_W-1:0]  tn;
	logic [RAW_W-1:0]        tn_mag;
	logic signed [SUM_W-1:0] bsum;
	logic [SUM_W-1:0]        bsum_mag;

	always_comb begin
		tn       = TN_W'(traw_q) + TN_W'(TEMP_OFFSET_RAW);
		tn_mag   = tn[TN_W-1] ? RAW_W'(-tn) : RAW_W'(tn);
		bsum     = sum_q[ax_q];
		bsum_mag = bsum[SUM_W-1] ? SUM_W'(-bsum) : SUM_W'(bsum);
	end

	// Rate saturation after the product
	logic signed [PROD_W-1:0] prod_shr;
	logic signed [RATE_W-1:0] rate_sat;

	always_comb begin
		prod_shr = prod_q >>> DPS_SHIFT;
		if (prod_shr > PROD_W'(RATE_MAX)) begin
			rate_sat = RATE_W'(RATE_MAX);
		end else if (prod_shr < PROD_W'(RATE_MIN)) begin
			rate_sat = RATE_W'(RATE_MIN);
		end else begin
			rate_sat = RATE_W'(prod_shr);
		end
	end

	// Bias from the quotient magnitude, saturated
	logic signed [RATE_W-1:0] bias_sat;

	always_comb begin
		if (neg_q) begin
			if (quo_q > DIV_W'(RATE_NEG_MAG)) begin
				bias_sat = RATE_W'(RATE_MIN);
			end else begin
				bias_sat = -$signed(quo_q[RATE_W-1:0]);
			end
		end else begin
			if (quo_q > DIV_W'(RATE_MAX)) begin
				bias_sat = RATE_W'(RATE_MAX);
			end else begin
				bias_sat = $signed(quo_q[RATE_W-1:0]);
			end
		end
	end

	// Temperature: floor division from the magnitude quotient, offset, saturate
	logic signed [TSUM_W-1:0] tq_floor;
	logic signed [TSUM_W-1:0] t_sum;
	logic signed [TEMP_W-1:0] temp_sat;

	always_comb begin
		if (neg_q) begin
			tq_floor = -(TSUM_W'(quo_q[TQ_W-1:0]) + TSUM_W'(rem_q != '0));
		end else begin
			tq_floor = TSUM_W'(quo_q[TQ_W-1:0]);
		end
		t_sum = (TSUM_W'(TEMP_BASE_C) <<< FRAC_BITS) + tq_floor;
		if (t_sum > TSUM_W'(TEMP_MAX)) begin
			temp_sat = TEMP_W'(TEMP_MAX);
		end else if (t_sum < TSUM_W'(TEMP_MIN)) begin
			temp_sat = TEMP_W'(TEMP_MIN);
		end else begin
			temp_sat = TEMP_W'(t_sum);
		end
	end

	// Configuration register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_samples_q <= CAL_SAMPLES_RST;
			dps_q         <= DPS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_CAL_SAMPLES: cal_samples_q <= cfg_data;
				REG_DPS_PER_LSB: dps_q         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_req) begin
						state_d = ST_DONE;
					end else if (cal_q) begin
						state_d = (run_ends && good_nxt != '0) ? ST_BLOAD : ST_DONE;
					end else if (!in_ok) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_DIFF;
					end
				end
			end
			ST_DIFF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_SAT;
			ST_SAT:   state_d = (ax_q == AX_LAST) ? ST_TLOAD : ST_DIFF;
			ST_TLOAD: state_d = ST_TDIV;
			ST_TDIV:  state_d = (cnt_q == CNT_W'(1)) ? ST_TFIX : ST_TDIV;
			ST_TFIX:  state_d = ST_DONE;
			ST_BLOAD: state_d = ST_BDIV;
			ST_BDIV:  state_d = (cnt_q == CNT_W'(1)) ? ST_BFIX : ST_BDIV;
			ST_BFIX:  state_d = (ax_q == AX_LAST) ? ST_DONE : ST_BLOAD;
			ST_DONE:  state_d = (!m_tvalid_q || m_tready) ? ST_IDLE : ST_DONE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer strobes
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:  ctrl.take      = 1'b1;
			ST_TLOAD: ctrl.temp_load = 1'b1;
			ST_BLOAD: ctrl.bias_load = 1'b1;
			ST_TDIV:  ctrl.div_step  = 1'b1;
			ST_BDIV:  ctrl.div_step  = 1'b1;
			ST_DONE:  ctrl.emit      = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	assign s_tready = ctrl.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q      <= 1'b0;
			left_q     <= '0;
			good_q     <= '0;
			ax_q       <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				sum_q[i]  <= '0;
				bias_q[i] <= '0;
			end
		end else begin
			// Calibration bookkeeping on each input transfer
			if (ctrl.take && s_tvalid) begin
				ax_q <= '0;
				if (in_req) begin
					good_q <= '0;
					left_q <= start_cnt;
					cal_q  <= (start_cnt != '0);
					for (int i = 0; i < NUM_AXES; i++) begin
						sum_q[i] <= '0;
					end
				end else if (cal_q) begin
					if (in_ok) begin
						for (int i = 0; i < NUM_AXES; i++) begin
							sum_q[i] <= sum_q[i] + SUM_W'(in_gyro[i]);
						end
					end
					good_q <= good_nxt;
					left_q <= left_q - COUNT_BITS'(1);
					if (run_ends) begin
						cal_q <= 1'b0;
					end
				end
			end

			// Axis walk
			if (state_q == ST_SAT) begin
				ax_q <= (ax_q == AX_LAST) ? 2'd0 : ax_q + 2'd1;
			end
			if (state_q == ST_BFIX) begin
				bias_q[ax_q] <= bias_sat;
				ax_q         <= (ax_q == AX_LAST) ? 2'd0 : ax_q + 2'd1;
			end

			// Divider step count
			if (ctrl.temp_load || ctrl.bias_load) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (ctrl.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end

			// Output register valid
			if (ctrl.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Capture the item and decide the status
		if (ctrl.take && s_tvalid) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_q[i]  <= in_gyro[i];
				rate_q[i] <= '0;
			end
			traw_q <= in_temp;
			temp_q <= '0;
			if (in_req) begin
				status_q <= (start_cnt != '0) ? STS_CAL_START : STS_CAL_FAIL;
			end else if (cal_q) begin
				if (run_ends) begin
					status_q <= (good_nxt == '0) ? STS_CAL_FAIL : STS_CAL_OK;
				end else begin
					status_q <= STS_CAL_SAMPLE;
				end
			end else if (!in_ok) begin
				status_q <= STS_READ_FAIL;
			end else begin
				status_q <= STS_READING;
			end
		end

		// Rate: scaled raw minus bias, product, then shift and saturate
		if (state_q == ST_DIFF) begin
			diff_q <= (DIFF_W'(raw_q[ax_q]) <<< FRAC_BITS) - DIFF_W'(bias_q[ax_q]);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(diff_q) * PROD_W'($signed({1'b0, dps_q}));
		end
		if (state_q == ST_SAT) begin
			rate_q[ax_q] <= rate_sat;
		end

		// Divider loads and steps
		if (ctrl.temp_load) begin
			neg_q <= tn[TN_W-1];
			quo_q <= DIV_W'(tn_mag) << FRAC_BITS;
			rem_q <= '0;
			dvs_q <= DVS_W'(TEMP_DIV);
		end else if (ctrl.bias_load) begin
			neg_q <= bsum[SUM_W-1];
			quo_q <= DIV_W'(bsum_mag) << FRAC_BITS;
			rem_q <= '0;
			dvs_q <= DVS_W'(good_q);
		end else if (ctrl.div_step) begin
			quo_q <= {quo_q[DIV_W-2:0], div_ge};
			rem_q <= div_rem_nxt[DVS_W-1:0];
		end

		if (state_q == ST_TFIX) begin
			temp_q <= temp_sat;
		end

		// Result into the output register
		if (ctrl.emit) begin
			m_tdata_q <= OUT_DATA_W'({temp_q, rate_q[2], rate_q[1], rate_q[0]});
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks on the sequencer and calibration state
	`GBCC_ASSERT_NEXT(a_take_leaves_idle, clk, arst_n, s_tvalid && s_tready,
		state_q != ST_IDLE, "accepted item did not start processing")
	`GBCC_ASSERT_NOW(a_div_count_live, clk, arst_n,
		state_q == ST_TDIV || state_q == ST_BDIV,
		cnt_q != '0, "divider running with an empty step count")
	`GBCC_ASSERT_NOW(a_run_matches_left, clk, arst_n, 1'b1,
		cal_q == (left_q != '0), "calibration flag disagrees with samples left")
	`GBCC_ASSERT_NOW(a_nonreading_zero, clk, arst_n,
		m_tvalid && m_tuser != STS_READING,
		m_tdata == '0, "non-reading result carries nonzero data")

endmodule

`default_nettype wire

### tb/gyro_bias_calibrate_convert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration result checker
// Watches the register, input and result channels of the gyro bias block.
// Keeps its own copy of the calibration state, predicts one result per
// accepted input transfer, and compares each result transfer field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_convert_checker
	import gbcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic [STATUS_W-1:0]   m_tuser,
	output int                         fail_count,
	output int                         pending,
	output int                         results_seen
);

	localparam longint COUNT_MAX  = (64'sd1 << COUNT_BITS_DEF) - 1;
	localparam longint FRAC_SCALE = 64'sd1 << FRAC_BITS_DEF;
	localparam int     TEMP_LSB   = NUM_AXES * RATE_W;
	localparam int     PAD_LSB    = TEMP_LSB + TEMP_W;
	localparam int     MAX_LINES  = 100;

	typedef struct packed {
		status_t                         status;
		logic [NUM_AXES-1:0][RATE_W-1:0] rate;
		logic [TEMP_W-1:0]               temp;
	} gyro_result_t;

	// Register copies and calibration state
	logic [CFG_W-1:0] run_length;
	logic [CFG_W-1:0] dps_scale;
	logic             in_cal;
	longint           left_cnt;
	longint           good_cnt;
	longint           axis_acc [NUM_AXES];
	longint           axis_offset [NUM_AXES];

	gyro_result_t expected_results [$];

	function automatic longint saturate(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Advances the calibration state by one input item and returns its result.
	function automatic gyro_result_t calibrate_or_convert(input logic req_start,
			input logic read_ok, input logic [IN_DATA_W-1:0] raw_bits);
		gyro_result_t res;
		longint       raw [NUM_AXES];
		longint       raw_temp;
		longint       scaled;
		longint       mag;
		longint       num;
		longint       quot;
		res = '0;
		for (int a = 0; a < NUM_AXES; a++)
			raw[a] = $signed(raw_bits[a*RAW_W +: RAW_W]);
		raw_temp = $signed(raw_bits[NUM_AXES*RAW_W +: RAW_W]);

		if (req_start) begin
			// A start clears the sums and arms a fresh run, or reports an empty one.
			left_cnt = (run_length > COUNT_MAX) ? COUNT_MAX : longint'(run_length);
			good_cnt = 0;
			foreach (axis_acc[a])
				axis_acc[a] = 0;
			in_cal = (left_cnt != 0);
			res.status = in_cal ? STS_CAL_START : STS_CAL_FAIL;
		end else if (in_cal) begin
			// A bad read still uses up its slot in the run.
			if (read_ok) begin
				foreach (axis_acc[a])
					axis_acc[a] += raw[a];
				good_cnt++;
			end
			left_cnt--;
			res.status = STS_CAL_SAMPLE;
			if (left_cnt == 0) begin
				in_cal = 1'b0;
				if (good_cnt == 0) begin
					res.status = STS_CAL_FAIL;
				end else begin
					// Average with the fraction kept, truncated toward zero.
					foreach (axis_offset[a]) begin
						scaled = axis_acc[a] * FRAC_SCALE;
						mag = ((scaled < 0) ? -scaled : scaled) / good_cnt;
						axis_offset[a] = saturate((scaled < 0) ? -mag : mag, RATE_MIN, RATE_MAX);
					end
					res.status = STS_CAL_OK;
				end
			end
		end else if (!read_ok) begin
			res.status = STS_READ_FAIL;
		end else begin
			// Bias-corrected rate, floored by the arithmetic shift.
			for (int a = 0; a < NUM_AXES; a++) begin
				num = (raw[a] * FRAC_SCALE - axis_offset[a]) * longint'(dps_scale);
				quot = saturate(num >>> DPS_SHIFT, RATE_MIN, RATE_MAX);
				res.rate[a] = quot[RATE_W-1:0];
			end
			// Temperature with a floored division.
			num = (raw_temp + TEMP_OFFSET_RAW) * FRAC_SCALE;
			quot = num / TEMP_DIV;
			if ((num % TEMP_DIV) != 0 && num < 0)
				quot--;
			quot = saturate(TEMP_BASE_C * FRAC_SCALE + quot, TEMP_MIN, TEMP_MAX);
			res.temp = quot[TEMP_W-1:0];
			res.status = STS_READING;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
			input logic [OUT_DATA_W-1:0] want);
		fail_count++;
		if (fail_count <= MAX_LINES)
			$display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	// Channel monitor: register writes, result comparison, then prediction.
	always @(posedge clk or negedge arst_n) begin
		gyro_result_t want;
		if (!arst_n) begin
			run_length = CAL_SAMPLES_RST;
			dps_scale = DPS_RST;
			in_cal = 1'b0;
			left_cnt = 0;
			good_cnt = 0;
			foreach (axis_acc[a]) begin
				axis_acc[a] = 0;
				axis_offset[a] = 0;
			end
			expected_results.delete();
			fail_count = 0;
			results_seen = 0;
			pending <= 0;
		end else begin
			// Register writes must land only while the block is idle; the block does not enforce it.
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					REG_CAL_SAMPLES: run_length = cfg_data;
					REG_DPS_PER_LSB: dps_scale = cfg_data;
					default: ;
				endcase
			end

			// Compare each result transfer with the oldest prediction.
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", m_tdata, '0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
					for (int a = 0; a < NUM_AXES; a++) begin
						if (m_tdata[a*RATE_W +: RATE_W] !== want.rate[a])
							report_mismatch($sformatf("rate of axis %0d", a),
								m_tdata[a*RATE_W +: RATE_W], want.rate[a]);
					end
					if (m_tdata[TEMP_LSB +: TEMP_W] !== want.temp)
						report_mismatch("temperature", m_tdata[TEMP_LSB +: TEMP_W], want.temp);
					if (m_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
						report_mismatch("padding bits", m_tdata[OUT_DATA_W-1:PAD_LSB], '0);
				end
			end

			// Predict the result of each accepted input transfer.
			if (s_tvalid && s_tready)
				expected_results.push_back(calibrate_or_convert(s_tuser[0], s_tuser[1], s_tdata));

			pending <= expected_results.size();
		end
	end

endmodule

### tb/gyro_bias_calibrate_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration testbench
// Drives directed and random readings, calibration runs and register writes
// into the gyro bias block with random idling on both streams, while a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_convert_tb
	import gbcc_pkg::*;
();

	localparam int     CLK_PERIOD    = 8;
	localparam int     RESET_CYCLES  = 8;
	localparam int     ITEM_TARGET   = 1350;
	localparam int     SETTLE_CYCLES = 200;
	localparam longint TIMEOUT_NS    = 64'd40_000_000;
	localparam logic   REQ_SAMPLE    = 1'b0;
	localparam logic   REQ_START     = 1'b1;
	localparam logic [CFG_W-1:0] RUN_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	// gyro_x[15:0], gyro_y[31:16], gyro_z[47:32], temp_raw[63:48]
	logic [IN_DATA_W-1:0]  s_tdata;
	// req_type[0], sample_ok[1]
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// rate_x[24:0], rate_y[49:25], rate_z[74:50], temp_q8[91:75], zeros above
	logic [OUT_DATA_W-1:0] m_tdata;
	// status[2:0]
	logic [STATUS_W-1:0]   m_tuser;

	// When set, neither stream idles.
	logic steady = 1'b0;

	int fail_count;
	int pending;
	int results_seen;
	int items_sent = 0;
	int runs_started = 0;
	int reg_writes = 0;

	gyro_bias_calibrate_convert u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	gyro_bias_calibrate_convert_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Result side stalls about one cycle in ten outside the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 10);
	end

	// Run limit
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results outstanding.", pending);
		$display("FAIL");
		$finish;
	end

	// Raw value biased toward the extremes and toward zero.
	function automatic logic [RAW_W-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 63)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	// One input transfer, with an occasional gap before it.
	task automatic send_item(input logic req, input logic ok, input logic [RAW_W-1:0] gx,
			input logic [RAW_W-1:0] gy, input logic [RAW_W-1:0] gz, input logic [RAW_W-1:0] tr);
		if (!steady && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(20, 150)) @(posedge clk);
			else
				repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {tr, gz, gy, gx};
		s_tuser <= {ok, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (req == REQ_START)
			runs_started++;
	endtask

	// Hold the input side until every predicted result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Stimulus and verdict
	initial begin
		logic [CFG_W-1:0] cur_run;
		logic [CFG_W-1:0] new_value;
		logic [RAW_W-1:0] base_x;
		logic [RAW_W-1:0] base_y;
		logic [RAW_W-1:0] base_z;
		int               ok_pct;
		int               run_items;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_addr <= '0;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Readings at zero bias with the field extremes, and a bad read.
		send_item(REQ_SAMPLE, 1'b1, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000);
		send_item(REQ_SAMPLE, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF);
		send_item(REQ_SAMPLE, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);

		// Short run: extreme samples around a bad read give the extreme bias.
		wait_drained();
		write_reg(REG_CAL_SAMPLES, 16'd3);
		send_item(REQ_START, 1'b1, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		send_item(REQ_SAMPLE, 1'b1, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
		send_item(REQ_SAMPLE, 1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'h0000);
		send_item(REQ_SAMPLE, 1'b1, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);

		// Largest scale against that bias; the temperature at its offset point.
		wait_drained();
		write_reg(REG_DPS_PER_LSB, 16'hFFFF);
		send_item(REQ_SAMPLE, 1'b1, 16'h7FFF, 16'h8000, 16'h5A5A, 16'hCC70);
		send_item(REQ_SAMPLE, 1'b1, 16'h8000, 16'h7FFF, 16'hA5A5, 16'h0000);

		// Restart in the middle of a run, then a run of only bad reads.
		send_item(REQ_START, 1'b0, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		send_item(REQ_SAMPLE, 1'b1, 16'h4000, 16'hC000, 16'h0100, 16'h0000);
		send_item(REQ_START, 1'b1, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		repeat (3)
			send_item(REQ_SAMPLE, 1'b0, pick_raw(), pick_raw(), pick_raw(), pick_raw());

		// Start with a run length of zero.
		wait_drained();
		write_reg(REG_CAL_SAMPLES, 16'd0);
		send_item(REQ_START, 1'b1, pick_raw(), pick_raw(), pick_raw(), pick_raw());

		// Zero scale gives zero rates.
		wait_drained();
		write_reg(REG_DPS_PER_LSB, 16'd0);
		send_item(REQ_SAMPLE, 1'b1, 16'h7FFF, 16'h8000, 16'h1111, 16'h2222);

		// Smallest scale; longest run cut short by a one-sample run.
		wait_drained();
		write_reg(REG_DPS_PER_LSB, 16'd1);
		write_reg(REG_CAL_SAMPLES, RUN_MAX);
		send_item(REQ_SAMPLE, 1'b1, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000);
		send_item(REQ_START, 1'b1, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		send_item(REQ_SAMPLE, 1'b1, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		send_item(REQ_SAMPLE, 1'b1, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		wait_drained();
		write_reg(REG_CAL_SAMPLES, 16'd1);
		send_item(REQ_START, 1'b0, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		send_item(REQ_SAMPLE, 1'b1, 16'h0123, 16'hFEDC, 16'h7F00, pick_raw());
		send_item(REQ_SAMPLE, 1'b1, pick_raw(), pick_raw(), pick_raw(), pick_raw());
		cur_run = 16'd1;

		// Random phases, each starting from an idle block.
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			steady <= (items_sent >= 500 && items_sent < 800);

			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 19))
					0: new_value = 16'd0;
					1: new_value = RUN_MAX;
					2, 3, 4: new_value = 16'($urandom_range(13, 40));
					default: new_value = 16'($urandom_range(1, 12));
				endcase
				write_reg(REG_CAL_SAMPLES, new_value);
				cur_run = new_value;
			end
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0: new_value = 16'd1;
					1: new_value = 16'hFFFF;
					default: new_value = 16'($urandom_range(1, 65535));
				endcase
				write_reg(REG_DPS_PER_LSB, new_value);
			end

			if ($urandom_range(0, 4) != 0) begin
				// Calibration run around a common offset, then readings.
				ok_pct = ($urandom_range(0, 9) == 0) ? 0 : 85;
				base_x = pick_raw();
				base_y = pick_raw();
				base_z = pick_raw();
				send_item(REQ_START, 1'($urandom_range(0, 1)), pick_raw(), pick_raw(),
					pick_raw(), pick_raw());
				run_items = (cur_run > 40) ? 40 : int'(cur_run);
				repeat (run_items)
					send_item(REQ_SAMPLE, $urandom_range(0, 99) < ok_pct,
						base_x + 16'($urandom_range(0, 255)) - 16'd128,
						base_y + 16'($urandom_range(0, 255)) - 16'd128,
						base_z + 16'($urandom_range(0, 255)) - 16'd128,
						pick_raw());
				repeat ($urandom_range(3, 15))
					send_item(REQ_SAMPLE, $urandom_range(0, 99) < 90, pick_raw(), pick_raw(),
						pick_raw(), pick_raw());
			end else begin
				// Loose mix of starts, samples and bad reads.
				repeat ($urandom_range(5, 15))
					send_item($urandom_range(0, 99) < 15, 1'($urandom_range(0, 1)), pick_raw(),
						pick_raw(), pick_raw(), pick_raw());
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d items, %0d calibration starts, %0d register writes.",
			items_sent, runs_started, reg_writes);
		$display("Checked %0d results over readings, bad reads, full, restarted, empty %s",
			results_seen, "and all-bad runs, and scale extremes.");
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
